FILE: src/slp_pkg.sv
// Shared types, constants and the shadow mask table for the shadow lift pixel block.
// Depends on nothing; every other file of the block imports it.
package slp_pkg;

	localparam int FRAC_BITS        = 12;
	localparam int MASK_TABLE_DEPTH = 256;
	localparam int IDX_W            = $clog2(MASK_TABLE_DEPTH);
	localparam int MASK_W           = FRAC_BITS + 1;
	localparam int CH_W             = 16;
	localparam int OFFSET_W         = 14;

	localparam int LUMA_W      = 34;
	localparam int LUMA_SHIFT  = 16;
	localparam int LUM_W       = LUMA_W - LUMA_SHIFT;
	localparam int IDX_PROD_W  = FRAC_BITS + IDX_W + 1;
	localparam int PROD_W      = OFFSET_W + MASK_W + 1;
	localparam int DELTA_W     = PROD_W - FRAC_BITS;
	localparam int SUM_W       = CH_W + 2;

	localparam logic signed [LUMA_W-1:0] COEF_R     = LUMA_W'(13933);
	localparam logic signed [LUMA_W-1:0] COEF_G     = LUMA_W'(46871);
	localparam logic signed [LUMA_W-1:0] COEF_B     = LUMA_W'(4732);
	localparam logic signed [LUMA_W-1:0] LUMA_ROUND = LUMA_W'(32768);
	localparam logic [LUM_W-1:0]         LUM_HALF   = LUM_W'(2 ** (FRAC_BITS - 1));
	localparam logic signed [PROD_W-1:0] LIFT_ROUND = PROD_W'(2 ** (FRAC_BITS - 1));
	localparam logic signed [SUM_W-1:0]  SAT_MAX    = SUM_W'(32767);
	localparam logic signed [SUM_W-1:0]  SAT_MIN    = -SUM_W'(32768);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint unsigned ONE_Q30 = 64'd1 << 30;

	typedef struct packed {
		logic signed [CH_W-1:0] red;
		logic signed [CH_W-1:0] green;
		logic signed [CH_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic signed [CH_W-1:0] red_out;
		logic signed [CH_W-1:0] green_out;
		logic signed [CH_W-1:0] blue_out;
	} result_t;

	typedef struct packed {
		pixel_t           pixel;
		logic             mask_zero;
		logic [IDX_W-1:0] idx;
	} mid_t;

	typedef logic [MASK_W-1:0] mask_tab_t [MASK_TABLE_DEPTH];

	// Shift and subtract division, used only while the constant table is built.
	function automatic longint unsigned div_u64(input longint unsigned num,
			input longint unsigned dvs);
		longint unsigned quo;
		longint unsigned rem;
		int              b;
		quo = '0;
		rem = '0;
		for (b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= dvs) begin
				rem    = rem - dvs;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Entry i holds cos^2(pi*i/(2*depth)) in Q12 from a 13 term Taylor series in Q30.
	function automatic mask_tab_t build_mask_tab();
		mask_tab_t         tab;
		longint unsigned   x;
		longint unsigned   x2;
		longint unsigned   term;
		longint unsigned   den;
		longint unsigned   c;
		longint unsigned   sq;
		longint            sum;
		int                i;
		int                k;
		for (i = 0; i < MASK_TABLE_DEPTH; i++) begin
			x    = (PI_Q30 * longint'(i)) / (2 * MASK_TABLE_DEPTH);
			x2   = (x * x + (64'd1 << 29)) >> 30;
			term = ONE_Q30;
			sum  = longint'(ONE_Q30);
			for (k = 1; k <= 12; k++) begin
				den  = longint'((2 * k - 1) * (2 * k)) << 30;
				term = div_u64(term * x2 + (den >> 1), den);
				if (k % 2 == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			c = (sum < 0) ? 64'd0 : longint'(sum);
			if (c > ONE_Q30) begin
				c = ONE_Q30;
			end
			sq = (c * c + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
			if (sq > (64'd1 << FRAC_BITS)) begin
				sq = 64'd1 << FRAC_BITS;
			end
			tab[i] = sq[MASK_W-1:0];
		end
		return tab;
	endfunction

	localparam mask_tab_t MASK_TAB = build_mask_tab();

endpackage

FILE: src/slp_queue.sv
// Four entry queue carrying classified pixels from the front part to the back part.
// Depends on slp_pkg for the item type and the queue sizes.
module slp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  slp_pkg::mid_t         wr_data,
	input  logic                  rd_en,
	output slp_pkg::mid_t         rd_data,
	output logic [slp_pkg::QCNT_W-1:0] count
);
	import slp_pkg::*;

	mid_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data = mem_q[rd_ptr_q];
	assign count   = cnt_q;

endmodule

FILE: src/slp_front.sv
// Front part: accepts pixels, forms clamped luminance and picks the mask table entry.
// Depends on slp_pkg; writes into the slp_queue instance held by the top level.
module slp_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  slp_pkg::pixel_t            pixel,
	output logic                       full,
	input  logic [slp_pkg::QCNT_W-1:0] q_count,
	output logic                       q_wr_en,
	output slp_pkg::mid_t              q_wr_data
);
	import slp_pkg::*;

	logic                     v_s1;
	pixel_t                   pix_s1;
	logic signed [LUMA_W-1:0] pr_s1;
	logic signed [LUMA_W-1:0] pg_s1;
	logic signed [LUMA_W-1:0] pb_s1;
	logic                     v_s2;
	mid_t                     item_s2;

	logic                     accept;
	logic [QCNT_W-1:0]        pending;
	logic signed [LUMA_W-1:0] luma_sum;
	logic                     lum_neg;
	logic [LUM_W-2:0]         lum_mag;
	logic [IDX_PROD_W-1:0]    idx_prod;
	mid_t                     item_next;

	// Every pixel in the pipeline already owns a queue slot, so the stages never stall.
	assign pending = q_count + QCNT_W'(v_s1) + QCNT_W'(v_s2);
	assign full    = (pending >= QCNT_W'(QUEUE_DEPTH));
	assign accept  = push && !full;

	always_comb begin
		luma_sum = pr_s1 + pg_s1 + pb_s1 + LUMA_ROUND;
		lum_neg  = luma_sum[LUMA_W-1];
		lum_mag  = luma_sum[LUMA_W-2:LUMA_SHIFT];
		idx_prod = IDX_PROD_W'(lum_mag[FRAC_BITS-2:0]) * IDX_PROD_W'(2 * MASK_TABLE_DEPTH);
		item_next.pixel     = pix_s1;
		item_next.mask_zero = !lum_neg && ({1'b0, lum_mag} >= LUM_HALF);
		item_next.idx       = lum_neg ? '0 : idx_prod[FRAC_BITS +: IDX_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pixel;
			pr_s1  <= LUMA_W'(pixel.red) * COEF_R;
			pg_s1  <= LUMA_W'(pixel.green) * COEF_G;
			pb_s1  <= LUMA_W'(pixel.blue) * COEF_B;
		end
		if (v_s1) begin
			item_s2 <= item_next;
		end
	end

	assign q_wr_en   = v_s2;
	assign q_wr_data = item_s2;

endmodule

FILE: src/slp_back.sv
// Back part: reads the mask, scales the offset, adds it to each channel with saturation.
// Depends on slp_pkg; holds the result queue seen on the output ports.
module slp_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [slp_pkg::QCNT_W-1:0]   q_count,
	input  slp_pkg::mid_t                q_rd_data,
	output logic                         q_rd_en,
	input  logic signed [slp_pkg::OFFSET_W-1:0] offset,
	output logic                         empty,
	input  logic                         pop,
	output slp_pkg::result_t             result
);
	import slp_pkg::*;

	logic                      v_s1;
	pixel_t                    pix_s1;
	logic [MASK_W-1:0]         mask_s1;
	logic                      v_s2;
	pixel_t                    pix_s2;
	logic signed [DELTA_W-1:0] delta_s2;

	result_t                   mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]         wr_ptr_q;
	logic [QPTR_W-1:0]         rd_ptr_q;
	logic [QCNT_W-1:0]         cnt_q;

	logic [QCNT_W-1:0]         pending;
	logic                      out_rd;
	logic [MASK_W-1:0]         mask_next;
	logic signed [PROD_W-1:0]  lift;
	result_t                   res_next;

	function automatic logic signed [CH_W-1:0] sat_add(
		input logic signed [CH_W-1:0]    ch,
		input logic signed [DELTA_W-1:0] d
	);
		logic signed [SUM_W-1:0] s;
		s = SUM_W'(ch) + SUM_W'(d);
		if (s > SAT_MAX) begin
			s = SAT_MAX;
		end else if (s < SAT_MIN) begin
			s = SAT_MIN;
		end
		return s[CH_W-1:0];
	endfunction

	assign pending = cnt_q + QCNT_W'(v_s1) + QCNT_W'(v_s2);
	assign q_rd_en = (q_count != '0) && (pending < QCNT_W'(QUEUE_DEPTH));
	assign out_rd  = pop && !empty;

	always_comb begin
		mask_next = q_rd_data.mask_zero ? '0 : MASK_TAB[q_rd_data.idx];
		lift      = PROD_W'(offset) * PROD_W'($signed({1'b0, mask_s1})) + LIFT_ROUND;
		res_next.red_out   = sat_add(pix_s2.red, delta_s2);
		res_next.green_out = sat_add(pix_s2.green, delta_s2);
		res_next.blue_out  = sat_add(pix_s2.blue, delta_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			v_s1 <= q_rd_en;
			v_s2 <= v_s1;
			if (v_s2) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (v_s2 && !out_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!v_s2 && out_rd) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd_en) begin
			pix_s1  <= q_rd_data.pixel;
			mask_s1 <= mask_next;
		end
		if (v_s1) begin
			pix_s2   <= pix_s1;
			delta_s2 <= lift[PROD_W-1:FRAC_BITS];
		end
		if (v_s2) begin
			mem_q[wr_ptr_q] <= res_next;
		end
	end

	assign empty  = (cnt_q == '0);
	assign result = mem_q[rd_ptr_q];

endmodule

FILE: src/shadow_lift_pixel.sv
// Top level of the shadow lift pixel block: configuration register and part wiring.
// Depends on slp_pkg, slp_front, slp_queue and slp_back.
//
// The block takes one pixel per clock cycle without gaps for as long as results are
// popped as fast as they appear. A pixel pushed into an otherwise empty block passes
// through the luminance and index pipeline, the middle queue, the mask and lift pipeline
// and the result queue before it shows on the result ports. The middle queue and the
// result queue have four entries each and the pipeline stages draw on their slots, so
// at most eight pixels are held while pop is low before full rises. The shadow offset is
// written through the configuration channel, which is always ready, and should only
// change while no pixel is in flight.
module shadow_lift_pixel (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  slp_pkg::pixel_t                   pixel,
	output logic                              full,
	output logic                              empty,
	input  logic                              pop,
	output slp_pkg::result_t                  result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic signed [slp_pkg::OFFSET_W-1:0] cfg_data
);
	import slp_pkg::*;

	logic signed [OFFSET_W-1:0] offset_q;
	logic                       q_wr_en;
	mid_t                       q_wr_data;
	logic                       q_rd_en;
	mid_t                       q_rd_data;
	logic [QCNT_W-1:0]          q_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			offset_q <= cfg_data;
		end
	end

	slp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pixel     (pixel),
		.full      (full),
		.q_count   (q_count),
		.q_wr_en   (q_wr_en),
		.q_wr_data (q_wr_data)
	);

	slp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr_en),
		.wr_data (q_wr_data),
		.rd_en   (q_rd_en),
		.rd_data (q_rd_data),
		.count   (q_count)
	);

	slp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_count   (q_count),
		.q_rd_data (q_rd_data),
		.q_rd_en   (q_rd_en),
		.offset    (offset_q),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

FILE: src/slp_checker.sv
// Port level checks for the shadow lift pixel block, attached by the bind at the end.
// Depends on slp_pkg for the result type.
module slp_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             push,
	input logic             full,
	input logic             empty,
	input logic             pop,
	input slp_pkg::result_t result
);
	import slp_pkg::*;

	localparam int OUTS_W       = 4;
	localparam int CAPACITY     = 8;
	localparam int FILL_LATENCY = 6;

	logic [OUTS_W-1:0] outstanding_q;
	logic              in_xfer;
	logic              out_xfer;

	assign in_xfer  = push && !full;
	assign out_xfer = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			outstanding_q <= outstanding_q + 1'b1;
		end else if (!in_xfer && out_xfer) begin
			outstanding_q <= outstanding_q - 1'b1;
		end
	end

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		(outstanding_q == '0) |-> empty)
		else $error("result shown with no pixel outstanding");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= OUTS_W'(CAPACITY))
		else $error("more pixels held than the block can store");

	a_idle_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(outstanding_q == '0) |-> !full)
		else $error("full raised while the block is idle");

	a_fill_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && (outstanding_q == '0)) |-> ##FILL_LATENCY !empty)
		else $error("result did not arrive in time after a transfer into an idle block");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed or vanished without a transfer");

endmodule

bind shadow_lift_pixel slp_checker u_slp_checker (.*);
